>>> sv/lpsd_pkg.sv
// Shared types, constants and pattern decode for the line position and stop detector.
`timescale 1ns / 1ps
`default_nettype none
package lpsd_pkg;

  localparam int DISTANCE_BITS = 24;
  localparam int CHANNELS      = 12;
  localparam int ARM_W         = 24;
  localparam int MISS_W        = 16;
  localparam int CONFIRM_W     = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  localparam logic [MISS_W-1:0] MISS_MAX = {MISS_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_LIMIT    = 3'd0,
    CFG_CENTER_FIRST  = 3'd1,
    CFG_CENTER_LAST   = 3'd2,
    CFG_MIN_BLACK     = 3'd3,
    CFG_LEAVE_CONFIRM = 3'd4,
    CFG_DETECT_CONFIRM = 3'd5,
    CFG_ARM_DISTANCE  = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    REQ_SAMPLE  = 1'b0,
    REQ_RESTART = 1'b1
  } req_t;

  typedef struct packed {
    logic                            req_type;
    logic [CHANNELS-1:0]             sensor_bits;
    logic signed [DISTANCE_BITS-1:0] distance_mm;
  } in_word_t;

  typedef struct packed {
    logic signed [4:0] line_position;
    logic              line_lost;
    logic              line_restored;
    logic [3:0]        center_blk_cnt;
    logic              stop_armed;
    logic              stop_detected;
  } out_word_t;

  typedef struct packed {
    logic [MISS_W-1:0]    miss_limit;
    logic [3:0]           center_first_channel;
    logic [3:0]           center_last_channel;
    logic [3:0]           min_black_channels;
    logic [CONFIRM_W-1:0] leave_confirm_count;
    logic [CONFIRM_W-1:0] detect_confirm_count;
    logic [ARM_W-1:0]     arm_distance_mm;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic                            restart;
    logic                            hit;
    logic                            all_clear;
    logic signed [4:0]               pos;
    logic [3:0]                      count;
    logic signed [DISTANCE_BITS-1:0] distance;
  } cls_word_t;

  typedef struct packed {
    logic              hit;
    logic signed [4:0] pos;
  } pat_t;

  function automatic pat_t decode_pattern(input logic [CHANNELS-1:0] bits);
    pat_t r;
    r.hit = 1'b1;
    r.pos = 5'sd0;
    unique case (bits)
      12'h001: r.pos = -5'sd11;
      12'h003: r.pos = -5'sd10;
      12'h002, 12'h007: r.pos = -5'sd9;
      12'h006: r.pos = -5'sd8;
      12'h004, 12'h00E: r.pos = -5'sd7;
      12'h00C: r.pos = -5'sd6;
      12'h008, 12'h01C: r.pos = -5'sd5;
      12'h018: r.pos = -5'sd4;
      12'h010, 12'h038: r.pos = -5'sd3;
      12'h030: r.pos = -5'sd2;
      12'h020, 12'h070: r.pos = -5'sd1;
      12'h060: r.pos = 5'sd0;
      12'h040, 12'h0E0: r.pos = 5'sd1;
      12'h0C0: r.pos = 5'sd2;
      12'h080, 12'h1C0: r.pos = 5'sd3;
      12'h180: r.pos = 5'sd4;
      12'h100, 12'h380: r.pos = 5'sd5;
      12'h300: r.pos = 5'sd6;
      12'h200, 12'h700: r.pos = 5'sd7;
      12'h600: r.pos = 5'sd8;
      12'h400, 12'hE00: r.pos = 5'sd9;
      12'hC00: r.pos = 5'sd10;
      12'h800: r.pos = 5'sd11;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/lpsd_front.sv
// Front end: pattern decode and center-window black count for each input word.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_front import lpsd_pkg::*; (
  input  var in_word_t  in_data,
  input  var cfg_t      cfg,
  output cls_word_t     cls
);

  pat_t       pat;
  logic [3:0] cnt;

  always_comb begin
    cnt = 4'd0;
    for (int i = 0; i < CHANNELS; i++) begin
      if ((4'(i) >= cfg.center_first_channel) && (4'(i) <= cfg.center_last_channel)) begin
        cnt = cnt + {3'd0, in_data.sensor_bits[i]};
      end
    end
  end

  assign pat = decode_pattern(in_data.sensor_bits);

  always_comb begin
    cls.restart   = (in_data.req_type == REQ_RESTART);
    cls.hit       = pat.hit;
    cls.all_clear = (in_data.sensor_bits == '0);
    cls.pos       = pat.pos;
    // restart words report no center count
    cls.count     = cls.restart ? 4'd0 : cnt;
    cls.distance  = in_data.distance_mm;
  end

endmodule
`default_nettype wire

>>> sv/lpsd_queue.sv
// Small FIFO between the classifying front end and the state-update back end.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_queue import lpsd_pkg::*; (
  input  var logic      clk,
  input  var logic      rst_n,
  input  var logic      push,
  input  var cls_word_t push_data,
  input  var logic      pop,
  output logic          full,
  output logic          not_empty,
  output cls_word_t     head
);

  cls_word_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/lpsd_back.sv
// Back end: line tracking and stop detector state, plus the output register.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_back import lpsd_pkg::*; (
  input  var logic      clk,
  input  var logic      rst_n,
  input  var cfg_t      cfg,
  input  var logic      q_not_empty,
  input  var cls_word_t q_head,
  output logic          q_pop,
  output logic          out_valid,
  input  var logic      out_stall,
  output out_word_t     out_data
);

  localparam int DIFF_W = DISTANCE_BITS + 2;

  logic signed [4:0]               pos_r, pos_nxt;
  logic [MISS_W-1:0]               miss_r, miss_nxt;
  logic                            lost_r, lost_nxt;
  logic                            restored_r, restored_nxt;
  logic                            armed_r, armed_nxt;
  logic                            stop_r, stop_nxt;
  logic [CONFIRM_W-1:0]            leave_r, leave_nxt;
  logic [CONFIRM_W-1:0]            detect_r, detect_nxt;
  logic signed [DISTANCE_BITS-1:0] start_r, start_nxt;
  logic                            out_valid_r, out_valid_nxt;
  out_word_t                       out_data_r, out_data_nxt;

  logic                            wide;
  logic signed [DIFF_W-1:0]        diff;
  logic                            far_enough;

  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  assign wide = (q_head.count >= cfg.min_black_channels);
  // exact difference, two guard bits so it never wraps
  assign diff = DIFF_W'(q_head.distance) - DIFF_W'(start_r);
  assign far_enough = (diff >= $signed({{(DIFF_W - ARM_W){1'b0}}, cfg.arm_distance_mm}));

  always_comb begin
    pos_nxt      = pos_r;
    miss_nxt     = miss_r;
    lost_nxt     = lost_r;
    restored_nxt = restored_r;
    armed_nxt    = armed_r;
    stop_nxt     = stop_r;
    leave_nxt    = leave_r;
    detect_nxt   = detect_r;
    start_nxt    = start_r;

    if (q_pop) begin
      if (q_head.restart) begin
        stop_nxt   = 1'b0;
        armed_nxt  = 1'b0;
        leave_nxt  = '0;
        detect_nxt = '0;
        start_nxt  = q_head.distance;
      end else begin
        // line tracking
        if (q_head.hit) begin
          pos_nxt  = q_head.pos;
          miss_nxt = miss_r >> 1;
          if (lost_r) begin
            restored_nxt = 1'b1;
          end
        end else if (q_head.all_clear) begin
          pos_nxt = 5'sd0;
          if (miss_r != MISS_MAX) begin
            miss_nxt = miss_r + 1'b1;
          end
          if (miss_nxt > cfg.miss_limit) begin
            lost_nxt     = 1'b1;
            restored_nxt = 1'b0;
          end
        end

        // stop detector
        if (!stop_r) begin
          if (!armed_r) begin
            if (!wide) begin
              if (leave_r < cfg.leave_confirm_count) begin
                leave_nxt = leave_r + 1'b1;
              end
            end else begin
              leave_nxt = '0;
            end
            if ((leave_nxt >= cfg.leave_confirm_count) && far_enough) begin
              armed_nxt = 1'b1;
            end
          end else if (wide) begin
            if (detect_r < cfg.detect_confirm_count) begin
              detect_nxt = detect_r + 1'b1;
            end
            if (detect_nxt >= cfg.detect_confirm_count) begin
              stop_nxt = 1'b1;
            end
          end else begin
            detect_nxt = '0;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.line_position  = pos_nxt;
      out_data_nxt.line_lost      = lost_nxt;
      out_data_nxt.line_restored  = restored_nxt;
      out_data_nxt.center_blk_cnt = q_head.count;
      out_data_nxt.stop_armed     = armed_nxt;
      out_data_nxt.stop_detected  = stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 5'sd0;
      miss_r      <= '0;
      lost_r      <= 1'b0;
      restored_r  <= 1'b0;
      armed_r     <= 1'b0;
      stop_r      <= 1'b0;
      leave_r     <= '0;
      detect_r    <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      miss_r      <= miss_nxt;
      lost_r      <= lost_nxt;
      restored_r  <= restored_nxt;
      armed_r     <= armed_nxt;
      stop_r      <= stop_nxt;
      leave_r     <= leave_nxt;
      detect_r    <= detect_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> sv/line_position_and_stop_detector.sv
// Top level: line position decoder and stop-line detector for a 12-channel line sensor.
// Timing: an accepted word is classified and written into the queue as it is accepted; its
//   result is then registered into the output register when that register is free.
// Throughput: one word per cycle with out_stall low; 2-entry queue and output reg absorb it.
// Reset: rst_n synchronous, active low; clears all tracking state, the queue and out_valid,
//   and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module line_position_and_stop_detector import lpsd_pkg::*; (
  input  var logic                  clk,
  input  var logic                  rst_n,
  // input channel
  input  var logic                  in_valid,
  output logic                      in_stall,
  input  var in_word_t              in_data,
  // result channel
  output logic                      out_valid,
  input  var logic                  out_stall,
  output out_word_t                 out_data,
  // configuration write port
  input  var logic                  cfg_we,
  input  var logic [CFG_IDX_W-1:0]  cfg_index,
  input  var logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r, cfg_nxt;
  cls_word_t cls;
  cls_word_t q_head;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      in_take;

  // ---------------------------------------------------------------------
  // Configuration registers; writes beyond the list are dropped.
  // ---------------------------------------------------------------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MISS_LIMIT:     cfg_nxt.miss_limit           = cfg_wdata[MISS_W-1:0];
        CFG_CENTER_FIRST:   cfg_nxt.center_first_channel = cfg_wdata[3:0];
        CFG_CENTER_LAST:    cfg_nxt.center_last_channel  = cfg_wdata[3:0];
        CFG_MIN_BLACK:      cfg_nxt.min_black_channels   = cfg_wdata[3:0];
        CFG_LEAVE_CONFIRM:  cfg_nxt.leave_confirm_count  = cfg_wdata[CONFIRM_W-1:0];
        CFG_DETECT_CONFIRM: cfg_nxt.detect_confirm_count = cfg_wdata[CONFIRM_W-1:0];
        CFG_ARM_DISTANCE:   cfg_nxt.arm_distance_mm      = cfg_wdata[ARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.miss_limit           <= 16'd10;
      cfg_r.center_first_channel <= 4'd3;
      cfg_r.center_last_channel  <= 4'd8;
      cfg_r.min_black_channels   <= 4'd4;
      cfg_r.leave_confirm_count  <= 8'd50;
      cfg_r.detect_confirm_count <= 8'd10;
      cfg_r.arm_distance_mm      <= 24'd500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Front: decode pattern and count the center window as the word arrives.
  // Accepts whenever the queue has room, independent of the result side.
  // ---------------------------------------------------------------------
  assign in_stall = q_full;
  assign in_take  = in_valid && !in_stall;

  lpsd_front u_front (
    .in_data (in_data),
    .cfg     (cfg_r),
    .cls     (cls)
  );

  lpsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (cls),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // ---------------------------------------------------------------------
  // Back: apply the classified word to the line and stop state into the output
  // register, one word per cycle unless out_stall holds that register full.
  // ---------------------------------------------------------------------
  lpsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // stop can only latch while armed; restart clears both together
  a_stop_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.stop_detected && !out_data.stop_armed))
    else $error("stop_detected without stop_armed");

  // restored is only set while lost, and lost is sticky
  a_restore_needs_lost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.line_restored && !out_data.line_lost))
    else $error("line_restored without line_lost");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.line_position >= -5'sd11) && (out_data.line_position <= 5'sd11))
    else $error("line_position out of range");

  // a queued word is always drained when the output register can take it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (q_not_empty && !out_valid) |=> out_valid)
    else $error("queued word not moved to output");

endmodule
`default_nettype wire

>>> bench/tb_line_position_and_stop_detector.sv
// Testbench for the line position and stop detector: random and directed words, scoreboard.
`timescale 1ns / 1ps
module tb_line_position_and_stop_detector;
  import lpsd_pkg::*;

  // Generous bound: about a thousand words under random stalls, plus register writes
  // and settling gaps.
  localparam int CYCLE_LIMIT = 40000;
  // Output passes through the queue and the output register after acceptance; a spare wait covers it.
  localparam int DRAIN_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  line_position_and_stop_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies and tracking state.
  // ---------------------------------------------------------------------------
  logic [15:0]       miss_limit_q;
  logic [3:0]        win_first_q;
  logic [3:0]        win_last_q;
  logic [3:0]        wide_min_q;
  logic [7:0]        leave_need_q;
  logic [7:0]        wide_need_q;
  logic [23:0]       arm_mm_q;

  logic signed [4:0] line_pos_q;
  logic [15:0]       misses_q;
  bit                lost_q;
  bit                restored_q;
  bit                armed_q;
  bit                stop_q;
  logic [7:0]        leave_run_q;
  logic [7:0]        wide_run_q;
  longint            start_mm_q;

  out_word_t         predicted_words[$];
  int                bad_fields = 0;
  int                cycle_count = 0;
  bit                calm = 1'b0;       // no idling on either side while set
  longint            odo_mm = 0;        // running odometer for well-formed laps

  // Work out the reading for one accepted word and advance the shadow state.
  function automatic out_word_t track_line_and_stop(input in_word_t w);
    out_word_t   r;
    logic [11:0] bits;
    logic [12:0] run_mask;
    int          i, lo, hi, n;
    longint      travel;
    bits = w.sensor_bits;
    n = 0;
    lo = -1;
    hi = -1;
    if (w.req_type == REQ_RESTART) begin
      // restart only touches the stop detector; line tracking is left alone
      stop_q = 1'b0;
      armed_q = 1'b0;
      leave_run_q = '0;
      wide_run_q = '0;
      start_mm_q = longint'($signed(w.distance_mm));
    end else begin
      for (i = 0; i < 12; i++) begin
        if (bits[i]) begin
          if (lo < 0) lo = i;
          hi = i;
        end
      end
      // A valid pattern is one unbroken run of 1 to 3 black channels; its
      // position is the run's center in half-channel steps around channel 5.5.
      run_mask = (13'd1 << (hi + 1)) - (13'd1 << lo);
      if (lo >= 0 && hi - lo < 3 && bits == run_mask[11:0]) begin
        line_pos_q = 5'(lo + hi - 11);
        misses_q = misses_q >> 1;
        if (lost_q) restored_q = 1'b1;
      end else if (bits == '0) begin
        line_pos_q = '0;
        if (misses_q != 16'hFFFF) misses_q = misses_q + 16'd1;
        if (misses_q > miss_limit_q) begin
          lost_q = 1'b1;
          restored_q = 1'b0;
        end
      end
      // center window; an inverted window counts nothing, channels past 11 are clear
      for (i = win_first_q; i <= win_last_q && i < 12; i++) n += bits[i];
      if (!stop_q) begin
        if (!armed_q) begin
          if (n < wide_min_q) begin
            if (leave_run_q < leave_need_q) leave_run_q = leave_run_q + 8'd1;
          end else begin
            leave_run_q = '0;
          end
          travel = longint'($signed(w.distance_mm)) - start_mm_q;
          if (leave_run_q >= leave_need_q && travel >= longint'(arm_mm_q)) armed_q = 1'b1;
        end else if (n >= wide_min_q) begin
          if (wide_run_q < wide_need_q) wide_run_q = wide_run_q + 8'd1;
          if (wide_run_q >= wide_need_q) stop_q = 1'b1;
        end else begin
          wide_run_q = '0;
        end
      end
    end
    r.line_position  = line_pos_q;
    r.line_lost      = lost_q;
    r.line_restored  = restored_q;
    r.center_blk_cnt = 4'(n);
    r.stop_armed     = armed_q;
    r.stop_detected  = stop_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare each accepted word with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (bad_fields < 100) $display("ERROR at %0t ns: %s", $time, msg);
    bad_fields++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic take_reading(input out_word_t got);
    out_word_t want;
    if (predicted_words.size() == 0) begin
      report_mismatch($sformatf("result %0h with nothing predicted", got));
      return;
    end
    want = predicted_words.pop_front();
    check_field("line_position", 8'(got.line_position), 8'(want.line_position));
    check_field("line_lost", 8'(got.line_lost), 8'(want.line_lost));
    check_field("line_restored", 8'(got.line_restored), 8'(want.line_restored));
    check_field("center_blk_cnt", 8'(got.center_blk_cnt), 8'(want.center_blk_cnt));
    check_field("stop_armed", 8'(got.stop_armed), 8'(want.stop_armed));
    check_field("stop_detected", 8'(got.stop_detected), 8'(want.stop_detected));
  endtask

  // Values read here are the ones from before the edge; drives go out by NBA.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) take_reading(out_data);
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers
  // ---------------------------------------------------------------------------
  // Offer one word, hold it until accepted, then predict its reading.
  // in_valid stays high on return so back-to-back words need no extra NBA.
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_words.push_back(track_line_and_stop(w));
  endtask

  // Drop valid, wait for every predicted reading, then let the pipe go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; only called once the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] value);
    case (idx)
      CFG_MISS_LIMIT:     miss_limit_q = value[15:0];
      CFG_CENTER_FIRST:   win_first_q  = value[3:0];
      CFG_CENTER_LAST:    win_last_q   = value[3:0];
      CFG_MIN_BLACK:      wide_min_q   = value[3:0];
      CFG_LEAVE_CONFIRM:  leave_need_q = value[7:0];
      CFG_DETECT_CONFIRM: wide_need_q  = value[7:0];
      CFG_ARM_DISTANCE:   arm_mm_q     = value;
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_window(input int first, input int last, input int wide_min);
    write_reg(CFG_CENTER_FIRST, 24'(first));
    write_reg(CFG_CENTER_LAST, 24'(last));
    write_reg(CFG_MIN_BLACK, 24'(wide_min));
  endtask

  task automatic write_stop_timing(input int leave, input int detect, input int arm);
    write_reg(CFG_LEAVE_CONFIRM, 24'(leave));
    write_reg(CFG_DETECT_CONFIRM, 24'(detect));
    write_reg(CFG_ARM_DISTANCE, 24'(arm));
  endtask

  function automatic in_word_t make_word(input req_t req, input logic [11:0] bits,
                                         input logic [23:0] mm);
    in_word_t w;
    w.req_type    = req;
    w.sensor_bits = bits;
    w.distance_mm = mm;
    return w;
  endfunction

  function automatic logic [23:0] next_odo();
    odo_mm += $urandom_range(0, 40);
    return odo_mm[23:0];
  endfunction

  // One of the 33 valid patterns: a run of 1 to 3 channels.
  function automatic logic [11:0] table_pattern();
    int lo, len;
    lo  = $urandom_range(0, 11);
    len = $urandom_range(1, (12 - lo) < 3 ? 12 - lo : 3);
    return 12'(((1 << len) - 1) << lo);
  endfunction

  // Push a sample to wide (set window channels) or narrow (clear them).
  function automatic logic [11:0] shape_bits(input logic [11:0] raw, input bit wide);
    logic [11:0] b;
    int          i, cnt;
    b = raw;
    cnt = 0;
    for (i = win_first_q; i <= win_last_q && i < 12; i++) cnt += b[i];
    for (i = win_first_q; i <= win_last_q && i < 12; i++) begin
      if (wide && cnt < wide_min_q && !b[i]) begin
        b[i] = 1'b1;
        cnt++;
      end
      if (!wide && cnt >= wide_min_q && cnt > 0 && b[i]) begin
        b[i] = 1'b0;
        cnt--;
      end
    end
    return b;
  endfunction

  // Noise word: mostly samples (valid patterns, some clear, some junk), a few restarts.
  function automatic in_word_t rand_word();
    int          k;
    logic [11:0] bits;
    logic [23:0] mm;
    k = $urandom_range(99);
    mm = (k % 2) ? next_odo() : 24'($urandom);
    if (k < 8) return make_word(REQ_RESTART, 12'($urandom), mm);
    if (k < 50) bits = table_pattern();
    else if (k < 65) bits = '0;
    else bits = 12'($urandom);
    return make_word(REQ_SAMPLE, bits, mm);
  endfunction

  // Well-formed lap: restart, narrow run to arm, wide run to latch stop, a few extras.
  task automatic run_stop_lap(input int narrow_n, input int wide_n, input bit broken);
    int j;
    send_word(make_word(REQ_RESTART, 12'($urandom), next_odo()));
    repeat (narrow_n)
      send_word(make_word(REQ_SAMPLE, shape_bits(12'($urandom), 1'b0), next_odo()));
    for (j = 0; j < wide_n; j++) begin
      // a broken lap drops one narrow sample into the wide run
      send_word(make_word(REQ_SAMPLE,
                          shape_bits(12'($urandom), !(broken && j == wide_n / 2)),
                          next_odo()));
    end
    // after the latch these must leave the detector alone
    repeat (3) send_word(make_word(REQ_SAMPLE, 12'($urandom), next_odo()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Corners at reset settings: field extremes, hold, clear and restart words.
  task automatic test_directed_corners();
    send_word(make_word(REQ_SAMPLE, 12'h000, 24'h000000));
    send_word(make_word(REQ_SAMPLE, 12'h001, 24'h000001));
    send_word(make_word(REQ_SAMPLE, 12'h800, 24'h7FFFFF));
    send_word(make_word(REQ_SAMPLE, 12'h007, 24'h000010));
    send_word(make_word(REQ_SAMPLE, 12'hE00, 24'h000020));
    send_word(make_word(REQ_SAMPLE, 12'h060, 24'h000030));
    send_word(make_word(REQ_SAMPLE, 12'h005, 24'h000040));  // gap in run: hold
    send_word(make_word(REQ_SAMPLE, 12'hFFF, 24'hFFFFFF));  // all black: hold
    send_word(make_word(REQ_SAMPLE, 12'h000, 24'h800000));
    send_word(make_word(REQ_RESTART, 12'hFFF, 24'h800000)); // count forced to 0
    send_word(make_word(REQ_SAMPLE, 12'h1F8, 24'h800010));  // whole window black
    send_word(make_word(REQ_RESTART, 12'h000, 24'h7FFFFF));
    send_word(make_word(REQ_SAMPLE, 12'h555, 24'h555555));
    send_word(make_word(REQ_SAMPLE, 12'hAAA, 24'hAAAAAA));
    send_word(make_word(REQ_SAMPLE, 12'h003, 24'h000100));
    send_word(make_word(REQ_SAMPLE, 12'hC00, 24'h000200));
    send_word(make_word(REQ_SAMPLE, 12'h000, 24'h000300));
    send_word(make_word(REQ_SAMPLE, 12'h180, 24'h000400));
    send_word(make_word(REQ_SAMPLE, 12'h249, 24'h000500));
    send_word(make_word(REQ_RESTART, 12'h000, 24'h000000));
    settle();
  endtask

  // Miss counter: clear runs around the limit, halving on hits, lost then restored.
  task automatic test_miss_counter();
    write_reg(CFG_MISS_LIMIT, 24'd5);
    repeat (5) send_word(make_word(REQ_SAMPLE, 12'h000, next_odo()));
    send_word(make_word(REQ_SAMPLE, table_pattern(), next_odo()));  // halved
    repeat (4) send_word(make_word(REQ_SAMPLE, 12'h000, next_odo()));  // crosses limit
    send_word(make_word(REQ_SAMPLE, 12'h505, next_odo()));          // junk: no change
    send_word(make_word(REQ_SAMPLE, table_pattern(), next_odo()));  // restored
    repeat (2) send_word(make_word(REQ_SAMPLE, 12'h000, next_odo()));
    send_word(make_word(REQ_SAMPLE, table_pattern(), next_odo()));
    settle();
  endtask

  // Random tracking words with a small miss limit, then limit 0 where every miss loses.
  task automatic test_line_tracking();
    write_reg(CFG_MISS_LIMIT, 24'd3);
    calm = 1'b1;
    repeat (80) send_word(rand_word());
    calm = 1'b0;
    repeat (40) send_word(rand_word());
    settle();
    write_reg(CFG_MISS_LIMIT, 24'd0);
    repeat (30) send_word(rand_word());
    settle();
  endtask

  // Arm and latch laps, first at the reset timing, then with random small settings.
  task automatic test_stop_laps();
    int lap, first, last, leave, detect;
    run_stop_lap(60, 12, 1'b0);
    settle();
    for (lap = 0; lap < 6; lap++) begin
      first  = $urandom_range(0, 4);
      last   = first + $urandom_range(2, 7);
      leave  = $urandom_range(0, 8);
      detect = $urandom_range(0, 6);
      write_window(first, last, $urandom_range(1, last - first + 1));
      write_stop_timing(leave, detect, $urandom_range(0, 200));
      run_stop_lap(leave + $urandom_range(0, 6), detect + $urandom_range(0, 3),
                   $urandom_range(2) == 0);
      settle();
    end
  endtask

  // Register extremes: zero and full confirm counts, odd windows, widest arm distance.
  task automatic test_register_extremes();
    // everything is wide and confirm counts are met at once
    write_window(0, 11, 0);
    write_stop_timing(0, 0, 0);
    run_stop_lap(0, 3, 1'b0);
    repeat (10) send_word(rand_word());
    settle();
    // inverted window counts nothing
    write_window(11, 0, 0);
    repeat (15) send_word(rand_word());
    settle();
    // window running past channel 11
    write_window(9, 15, 3);
    repeat (20) send_word(make_word(REQ_SAMPLE, shape_bits(12'($urandom), $urandom_range(1)),
                                    next_odo()));
    settle();
    // a wide sample can never occur
    write_window(0, 15, 15);
    run_stop_lap(5, 5, 1'b0);
    settle();
    // full signed span exactly meets the largest arm distance
    write_window(0, 11, 12);
    write_stop_timing(0, 0, 24'hFFFFFF);
    send_word(make_word(REQ_RESTART, 12'h000, 24'h800000));
    send_word(make_word(REQ_SAMPLE, 12'h000, 24'h7FFFFE));
    send_word(make_word(REQ_SAMPLE, 12'h000, 24'h7FFFFF));
    send_word(make_word(REQ_SAMPLE, 12'hFFF, 24'h7FFFFF));
    send_word(make_word(REQ_SAMPLE, 12'h001, 24'h000000));
    settle();
    // longest confirm runs
    write_window(4, 7, 2);
    write_stop_timing(255, 255, 0);
    run_stop_lap(258, 258, 1'b0);
    settle();
    // back to reset-like settings for a closing random stretch
    write_reg(CFG_MISS_LIMIT, 24'd10);
    write_window(3, 8, 4);
    write_stop_timing(50, 10, 500);
    repeat (40) send_word(rand_word());
    settle();
  endtask

  initial begin
    // shadow matches the block's reset values
    miss_limit_q = 16'd10;
    win_first_q  = 4'd3;
    win_last_q   = 4'd8;
    wide_min_q   = 4'd4;
    leave_need_q = 8'd50;
    wide_need_q  = 8'd10;
    arm_mm_q     = 24'd500;
    line_pos_q   = '0;
    misses_q     = '0;
    lost_q       = 1'b0;
    restored_q   = 1'b0;
    armed_q      = 1'b0;
    stop_q       = 1'b0;
    leave_run_q  = '0;
    wide_run_q   = '0;
    start_mm_q   = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_miss_counter();
    test_line_tracking();
    test_stop_laps();
    test_register_extremes();

    if (bad_fields == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
sv/lpsd_pkg.sv
sv/lpsd_front.sv
sv/lpsd_queue.sv
sv/lpsd_back.sv
sv/line_position_and_stop_detector.sv
bench/tb_line_position_and_stop_detector.sv
